### sv/ssam_pkg.sv
// ssam_pkg: shared types and constants for the signed shift-add multiplier
// no dependencies; imported by ssam_magnitude, ssam_core and the top level
package ssam_pkg;

  // fixed field widths of the stream payloads
  localparam int unsigned IN_FIELD_W = 16;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned IN_TDATA_W = 2 * IN_FIELD_W;
  localparam int unsigned OUT_TDATA_W = PROD_W;

  // sequencer states of the shift-add core
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } ssam_state_t;

endpackage

### sv/ssam_magnitude.sv
// ssam_magnitude: splits one two's complement operand into sign and magnitude
// depends on ssam_pkg for the input field width
module ssam_magnitude #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic [ssam_pkg::IN_FIELD_W-1:0] raw,
  output logic                            neg,
  output logic [OPERAND_WIDTH-1:0]        mag
);
  import ssam_pkg::*;

  logic [OPERAND_WIDTH-1:0] opnd;

  // take the low operand bits, zero fill when the operand is wider than the field
  generate
    if (OPERAND_WIDTH <= IN_FIELD_W) begin : g_trunc
      assign opnd = raw[OPERAND_WIDTH-1:0];
    end else begin : g_ext
      assign opnd = {{(OPERAND_WIDTH - IN_FIELD_W){1'b0}}, raw};
    end
  endgenerate

  // most negative value maps onto itself, which is its exact unsigned magnitude
  always_comb begin
    neg = opnd[OPERAND_WIDTH-1];
    mag = neg ? (~opnd + OPERAND_WIDTH'(1)) : opnd;
  end

endmodule

### sv/ssam_core.sv
// ssam_core: bit-serial shift-and-add engine with final sign correction
// depends on ssam_pkg (state type, widths) and ssam_magnitude
module ssam_core #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            start_ready,
  input  logic [ssam_pkg::IN_FIELD_W-1:0] mcand_raw,
  input  logic [ssam_pkg::IN_FIELD_W-1:0] mplier_raw,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [ssam_pkg::PROD_W-1:0]     res_data
);
  import ssam_pkg::*;

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned EXT_W = (PW > PROD_W) ? PW : PROD_W;
  localparam int unsigned CNT_W = (W > 2) ? $clog2(W) : 1;

  ssam_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     hi_r, hi_nxt;
  logic [W-1:0]     lo_r, lo_nxt;
  logic [W-1:0]     mcand_r, mcand_nxt;
  logic             neg_r, neg_nxt;

  logic             neg_a, neg_b;
  logic [W-1:0]     mag_a, mag_b;
  logic [W:0]       sum;
  logic [EXT_W-1:0] prod_ext, prod_sgn;

  // operand sign/magnitude split
  ssam_magnitude #(.OPERAND_WIDTH(W)) u_mag_a (
    .raw (mcand_raw),
    .neg (neg_a),
    .mag (mag_a)
  );

  ssam_magnitude #(.OPERAND_WIDTH(W)) u_mag_b (
    .raw (mplier_raw),
    .neg (neg_b),
    .mag (mag_b)
  );

  // one multiplier bit per cycle: conditional add into the upper half
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : {(W + 1){1'b0}});

  // sign correction on the finished magnitude
  always_comb begin
    prod_ext = EXT_W'({hi_r, lo_r});
    prod_sgn = neg_r ? (~prod_ext + EXT_W'(1)) : prod_ext;
    res_data = prod_sgn[PROD_W-1:0];
  end

  // sequencer: next state, counter and datapath updates
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    mcand_nxt   = mcand_r;
    neg_nxt     = neg_r;
    start_ready = 1'b0;
    res_valid   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        start_ready = 1'b1;
        if (start) begin
          hi_nxt    = '0;
          lo_nxt    = mag_b;
          mcand_nxt = mag_a;
          neg_nxt   = neg_a ^ neg_b;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        hi_nxt = sum[W:1];
        lo_nxt = {sum[0], lo_r[W-1:1]};
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_FIX: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    mcand_r <= mcand_nxt;
    neg_r   <= neg_nxt;
  end

endmodule

### sv/signed_shift_add_multiplier_top.sv
// Signed shift-add multiplier: at its input transfer an item is split into sign and
// magnitude and loaded into the core; the core then takes one multiplier bit per
// cycle through the single OPERAND_WIDTH-bit adder of the shift-add core, and last
// negates the product when the signs differ and hands it to the output register,
// waiting while that register is full. Only then can the core take the next item.
// The output register lets a new item start while a product
// still waits for its output transfer. Operands are the low OPERAND_WIDTH bits of
// each 16-bit field (zero filled above 16 bits); the product is the low 32 bits.
// depends on ssam_pkg and ssam_core
module signed_shift_add_multiplier_top #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ssam_pkg::IN_TDATA_W-1:0]  in_tdata,   // multiplicand[15:0], multiplier[31:16]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ssam_pkg::OUT_TDATA_W-1:0] out_tdata   // product[31:0]
);
  import ssam_pkg::*;

  logic              core_ready;
  logic              res_valid, res_ready;
  logic [PROD_W-1:0] res_data;
  logic              out_valid_r, out_valid_nxt;
  logic [PROD_W-1:0] out_data_r, out_data_nxt;

  assign in_tready = core_ready;

  ssam_core #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_tvalid & core_ready),
    .start_ready (core_ready),
    .mcand_raw   (in_tdata[IN_FIELD_W-1:0]),
    .mplier_raw  (in_tdata[IN_TDATA_W-1:IN_FIELD_W]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data)
  );

  // output register: refill when empty or when its transfer completes
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/tb.sv
// testbench for signed_shift_add_multiplier_top: directed corner operands, then random
// operands under three sender/receiver throttling phases and one long output stall
// depends on ssam_pkg and signed_shift_add_multiplier_top
module tb;
  import ssam_pkg::*;

  localparam int unsigned OPW         = 16;
  localparam int unsigned RAND_ITEMS  = 1800;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;

  // tracks products of accepted operand pairs and checks them in order
  class product_tracker;
    logic [PROD_W-1:0] expected_products[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // sign-magnitude shift-add product, low PROD_W bits kept
    function logic [PROD_W-1:0] predict_product(logic [IN_FIELD_W-1:0] mcand,
                                                logic [IN_FIELD_W-1:0] mplier);
      logic [63:0] op_mask;
      logic [63:0] acc_mask;
      logic [63:0] mag_a;
      logic [63:0] mag_b;
      logic [63:0] acc;
      logic        neg_a;
      logic        neg_b;
      op_mask  = (OPW >= 64) ? '1 : ((64'd1 << OPW) - 64'd1);
      acc_mask = (2 * OPW >= 64) ? '1 : ((64'd1 << (2 * OPW)) - 64'd1);
      mag_a = {{(64 - IN_FIELD_W){1'b0}}, mcand} & op_mask;
      mag_b = {{(64 - IN_FIELD_W){1'b0}}, mplier} & op_mask;
      neg_a = mag_a[OPW-1];
      neg_b = mag_b[OPW-1];
      if (neg_a) mag_a = (~mag_a + 64'd1) & op_mask;
      if (neg_b) mag_b = (~mag_b + 64'd1) & op_mask;
      // the most negative value maps to itself, which is its exact magnitude
      acc = '0;
      for (int unsigned i = 0; i < OPW; i++) begin
        if (mag_b[i]) acc = acc + (mag_a << i);
      end
      acc = acc & acc_mask;
      if (neg_a != neg_b) acc = ~acc + 64'd1;
      return acc[PROD_W-1:0];
    endfunction

    function void note_operands(logic [IN_FIELD_W-1:0] mcand, logic [IN_FIELD_W-1:0] mplier);
      expected_products.push_back(predict_product(mcand, mplier));
    endfunction

    function void check_product(logic [PROD_W-1:0] actual);
      logic [PROD_W-1:0] want;
      if (expected_products.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected product transfer: got %0d (0x%08h)", $signed(actual), actual);
        return;
      end
      want = expected_products.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("product mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                   $signed(want), want, $signed(actual), actual);
      end
    endfunction

    function int unsigned pending();
      return expected_products.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (expected_products.size() == 0);
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  product_tracker tracker = new();
  int unsigned    snd_idle_pct = 31;
  int unsigned    rcv_idle_pct = 68;
  bit             hold_req     = 1'b0;
  int unsigned    hold_left    = 0;
  int unsigned    cycle_count  = 0;

  signed_shift_add_multiplier_top #(.OPERAND_WIDTH(OPW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // observe transfers on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_product(out_tdata);
      if (in_tvalid && in_tready) tracker.note_operands(in_tdata[15:0], in_tdata[31:16]);
    end
  end

  // receiver: random backpressure, plus a long hold-off when requested
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
      @(posedge clk);
    end
  end

  // offer one operand pair and wait for its transfer
  task automatic send_operands(input logic [15:0] mcand, input logic [15:0] mplier);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {mplier, mcand};
    do @(posedge clk); while (!in_tready);
  endtask

  // corner values often, full-range values otherwise
  function automatic logic [15:0] random_operand();
    logic [15:0] v;
    case ($urandom_range(9))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = 16'h0000;
      3: v = 16'hffff;
      4: v = 16'h8001;
      5: begin
        v = 16'($urandom_range(15));
        if ($urandom_range(1)) v = -v;
      end
      default: v = 16'($urandom_range(16'hffff));
    endcase
    return v;
  endfunction

  initial begin
    logic [15:0] corner_a[$];
    logic [15:0] corner_b[$];
    corner_a = '{16'h0000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'h8000,
                 16'hffff, 16'hffff, 16'h0001, 16'h0000, 16'hffff, 16'h0005, 16'hfff9,
                 16'h3039, 16'haaaa, 16'h5555, 16'hffff, 16'h0001, 16'h0002, 16'h8001};
    corner_b = '{16'h0000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000,
                 16'hffff, 16'h0001, 16'hffff, 16'hffff, 16'h0000, 16'hfffd, 16'h0009,
                 16'ha460, 16'h5555, 16'haaaa, 16'h8000, 16'h0001, 16'h4000, 16'h8001};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: extremes, zero with either sign, mixed signs
    foreach (corner_a[i]) send_operands(corner_a[i], corner_b[i]);

    // phase one: sender idles less than receiver
    for (int unsigned n = 0; n < RAND_ITEMS / 3; n++)
      send_operands(random_operand(), random_operand());

    // phase two: roles swapped
    snd_idle_pct = 68;
    rcv_idle_pct = 31;
    for (int unsigned n = 0; n < RAND_ITEMS / 3; n++)
      send_operands(random_operand(), random_operand());

    // phase three: full rate, with a long output stall to fill the block
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req     = 1'b1;
    for (int unsigned n = 0; n < RAND_ITEMS / 3; n++)
      send_operands(random_operand(), random_operand());

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3 * (OPW + 2)) @(posedge clk);

    if (tracker.clean()) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### signed_shift_add_multiplier_top.f
sv/ssam_pkg.sv
sv/ssam_magnitude.sv
sv/ssam_core.sv
sv/signed_shift_add_multiplier_top.sv
tb/tb.sv
